>>> rtl/aabb_overlap_penetration_axis_assert.svh
`ifndef AABB_OVERLAP_PENETRATION_AXIS_ASSERT_SVH
`define AABB_OVERLAP_PENETRATION_AXIS_ASSERT_SVH

// same-cycle implication, off during reset
`define AOP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aop assertion failed");

// next-cycle implication, off during reset
`define AOP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aop assertion failed");

// next-cycle implication, always checked
`define AOP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("aop assertion failed");

`endif

>>> rtl/aop_pkg.sv
package aop_pkg;

    localparam int CW         = 32;
    localparam int HW         = 31;
    localparam int PW         = 32;
    localparam int IDXW       = 3;
    localparam int S_TDATA_W  = 384;
    localparam int M_TDATA_W  = 40;

    localparam int M_HIT_BIT  = 0;
    localparam int M_IDX_LSB  = 1;
    localparam int M_PEN_LSB  = M_IDX_LSB + IDXW;
    localparam int M_USED_W   = M_PEN_LSB + PW;

    localparam logic [PW-1:0] PEN_MAX = '1;

    localparam logic [IDXW-1:0] FACE_NEG_X = 3'd0;
    localparam logic [IDXW-1:0] FACE_POS_X = 3'd1;
    localparam logic [IDXW-1:0] FACE_NEG_Y = 3'd2;
    localparam logic [IDXW-1:0] FACE_POS_Y = 3'd3;
    localparam logic [IDXW-1:0] FACE_NEG_Z = 3'd4;
    localparam logic [IDXW-1:0] FACE_POS_Z = 3'd5;

    typedef struct packed {
        logic signed [CW-1:0] ctr_a;
        logic signed [CW-1:0] ctr_b;
        logic [HW-1:0]        half_a;
        logic [HW-1:0]        half_b;
    } t_axis_in;

    typedef struct packed {
        logic        ovl;
        logic        pos_face;
        logic [PW:0] pen;
    } t_axis_res;

    typedef struct packed {
        logic [PW-1:0]   pen;
        logic [IDXW-1:0] idx;
        logic            hit;
    } t_result;

endpackage

>>> rtl/aabb_overlap_penetration_axis.sv
// Overlap test of two axis-aligned boxes in signed Q16.16 with the face of
// least penetration. One box pair enters per transfer and one result leaves
// per transfer; a new pair is taken every cycle unless the output stalls,
// and the pair is held in the input register, then its result in the result register.
// Boxes that only touch on an axis do not overlap. Faces are numbered
// 0=-x 1=+x 2=-y 3=+y 4=-z 5=+z; on equal depths the lower number wins.
// Without overlap hit, axis_index and penetration are all zero.
module aabb_overlap_penetration_axis
    import aop_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // center_a_x, center_a_y, center_a_z, half_a_x, half_a_y, half_a_z,
    // center_b_x, center_b_y, center_b_z, half_b_x, half_b_y, half_b_z, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // hit, axis_index, penetration, zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int A_CX = 0;
    localparam int A_CY = A_CX + CW;
    localparam int A_CZ = A_CY + CW;
    localparam int A_HX = A_CZ + CW;
    localparam int A_HY = A_HX + HW;
    localparam int A_HZ = A_HY + HW;
    localparam int B_CX = A_HZ + HW;
    localparam int B_CY = B_CX + CW;
    localparam int B_CZ = B_CY + CW;
    localparam int B_HX = B_CZ + CW;
    localparam int B_HY = B_HX + HW;
    localparam int B_HZ = B_HY + HW;

    t_axis_in  n_ax_x, n_ax_y, n_ax_z;
    t_axis_in  r_ax_x, r_ax_y, r_ax_z;
    logic      r_in_vld;
    t_result   r_out;
    logic      r_out_vld;
    t_axis_res res_x, res_y, res_z;
    t_result   n_out;
    logic      adv;

    always_comb begin
        n_ax_x.ctr_a  = s_axis_tdata[A_CX +: CW];
        n_ax_y.ctr_a  = s_axis_tdata[A_CY +: CW];
        n_ax_z.ctr_a  = s_axis_tdata[A_CZ +: CW];
        n_ax_x.half_a = s_axis_tdata[A_HX +: HW];
        n_ax_y.half_a = s_axis_tdata[A_HY +: HW];
        n_ax_z.half_a = s_axis_tdata[A_HZ +: HW];
        n_ax_x.ctr_b  = s_axis_tdata[B_CX +: CW];
        n_ax_y.ctr_b  = s_axis_tdata[B_CY +: CW];
        n_ax_z.ctr_b  = s_axis_tdata[B_CZ +: CW];
        n_ax_x.half_b = s_axis_tdata[B_HX +: HW];
        n_ax_y.half_b = s_axis_tdata[B_HY +: HW];
        n_ax_z.half_b = s_axis_tdata[B_HZ +: HW];
    end

    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_ax_x <= n_ax_x;
            r_ax_y <= n_ax_y;
            r_ax_z <= n_ax_z;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    aop_axis u_axis_x (.i_axis(r_ax_x), .o_res(res_x));
    aop_axis u_axis_y (.i_axis(r_ax_y), .o_res(res_y));
    aop_axis u_axis_z (.i_axis(r_ax_z), .o_res(res_z));

    aop_select u_select (
        .i_res_x (res_x),
        .i_res_y (res_y),
        .i_res_z (res_z),
        .o_res   (n_out)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(M_TDATA_W-M_USED_W){1'b0}}, r_out};

endmodule

>>> rtl/aop_axis.sv
module aop_axis
    import aop_pkg::*;
(
    input  t_axis_in  i_axis,
    output t_axis_res o_res
);

    logic signed [CW:0]   d;
    logic [CW:0]          ad;
    logic [HW:0]          t;
    logic [CW+1:0]        m;

    always_comb begin
        d = {i_axis.ctr_b[CW-1], i_axis.ctr_b} - {i_axis.ctr_a[CW-1], i_axis.ctr_a};
        ad = d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
        t = {1'b0, i_axis.half_a} + {1'b0, i_axis.half_b};
        // penetration depth along this axis: t - |d|
        m = {2'b00, t} - {1'b0, ad};
        o_res.ovl      = !m[CW+1] && (m != '0);
        o_res.pos_face = !d[CW] && (d != '0);
        o_res.pen      = m[PW:0];
    end

endmodule

>>> rtl/aop_select.sv
module aop_select
    import aop_pkg::*;
(
    input  t_axis_res i_res_x,
    input  t_axis_res i_res_y,
    input  t_axis_res i_res_z,
    output t_result   o_res
);

    logic [PW:0]     best_pen;
    logic [IDXW-1:0] best_idx;
    logic            hit;

    always_comb begin
        best_pen = i_res_x.pen;
        best_idx = FACE_NEG_X | {2'b00, i_res_x.pos_face};
        if (i_res_y.pen < best_pen) begin
            best_pen = i_res_y.pen;
            best_idx = FACE_NEG_Y | {2'b00, i_res_y.pos_face};
        end
        if (i_res_z.pen < best_pen) begin
            best_pen = i_res_z.pen;
            best_idx = FACE_NEG_Z | {2'b00, i_res_z.pos_face};
        end
        hit = i_res_x.ovl && i_res_y.ovl && i_res_z.ovl;
        o_res = '0;
        if (hit) begin
            o_res.hit = 1'b1;
            o_res.idx = best_idx;
            o_res.pen = best_pen[PW] ? PEN_MAX : best_pen[PW-1:0];
        end
    end

endmodule

>>> rtl/aop_checker.sv
`include "aabb_overlap_penetration_axis_assert.svh"

module aop_checker
    import aop_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic            hit;
    logic [IDXW-1:0] idx;
    logic [PW-1:0]   pen;
    logic            m_stall;
    logic            idx_ok;

    assign hit     = m_axis_tdata[M_HIT_BIT];
    assign idx     = m_axis_tdata[M_IDX_LSB +: IDXW];
    assign pen     = m_axis_tdata[M_PEN_LSB +: PW];
    assign m_stall = m_axis_tvalid && !m_axis_tready;
    assign idx_ok  = (idx == FACE_NEG_X) || (idx == FACE_POS_X) || (idx == FACE_NEG_Y) ||
                     (idx == FACE_POS_Y) || (idx == FACE_NEG_Z) || (idx == FACE_POS_Z);

    `AOP_ASSERT_ALWAYS_NEXT(a_rst_no_valid, i_clk, !i_rst_n, !m_axis_tvalid)
    `AOP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `AOP_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, m_axis_tvalid && !hit, idx == FACE_NEG_X && pen == '0)
    `AOP_ASSERT_NOW(a_hit_sane, i_clk, i_rst_n, m_axis_tvalid && hit, pen != '0 && idx_ok)

endmodule

bind aabb_overlap_penetration_axis aop_checker u_aop_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import aop_pkg::*;

    localparam int  RANDOM_PAIRS   = 1150;
    localparam int  TAIL_PAIRS     = 150;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  LONG_HOLD      = 300;
    localparam int  LONG_HOLD_AT   = 400;
    localparam int  DRAIN_AT       = 700;
    localparam longint CTR_MAX     = 64'sd2147483647;
    localparam longint CTR_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic        wait_drain;
        logic [2:0][HW-1:0] hb;
        logic [2:0][CW-1:0] cb;
        logic [2:0][HW-1:0] ha;
        logic [2:0][CW-1:0] ca;
    } t_box_pair;

    typedef struct packed {
        logic [CW-1:0] ca;
        logic [CW-1:0] cb;
        logic [HW-1:0] ha;
        logic [HW-1:0] hb;
    } t_axis_span;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // center_a_x/y/z, half_a_x/y/z, center_b_x/y/z, half_b_x/y/z, zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // hit, axis_index, penetration, zero pad
    logic [M_TDATA_W-1:0] m_axis_tdata;

    t_box_pair pending_pairs[$];
    t_result   expected_contacts[$];
    t_box_pair drv_cur;
    t_box_pair build_pair;
    t_result   got_contact;
    t_result   want_contact;
    int        src_idle = 0;
    int        sink_hold = 0;
    int        sent_cnt = 0;
    int        res_cnt = 0;
    int        fail_count = 0;
    int        stall_cycles = 0;
    logic      quiet_tail = 1'b0;
    int        mode;

    aabb_overlap_penetration_axis dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic [S_TDATA_W-1:0] pack_pair(t_box_pair p);
        return S_TDATA_W'({p.hb, p.cb, p.ha, p.ca});
    endfunction

    function automatic t_result predict_contact(t_box_pair p);
        longint  neg_d[3];
        longint  pos_d[3];
        longint  d;
        longint  t;
        longint  ad;
        longint  pen;
        logic    ovl;
        t_result r;
        ovl = 1'b1;
        for (int k = 0; k < 3; k++) begin
            d = longint'($signed(p.cb[k])) - longint'($signed(p.ca[k]));
            t = longint'(p.ha[k]) + longint'(p.hb[k]);
            ad = (d < 0) ? -d : d;
            if (!(ad < t)) ovl = 1'b0;
            neg_d[k] = t + d;
            pos_d[k] = t - d;
        end
        r = '0;
        if (ovl) begin
            pen = neg_d[0];
            r.idx = FACE_NEG_X;
            if (pos_d[0] < pen) begin pen = pos_d[0]; r.idx = FACE_POS_X; end
            if (neg_d[1] < pen) begin pen = neg_d[1]; r.idx = FACE_NEG_Y; end
            if (pos_d[1] < pen) begin pen = pos_d[1]; r.idx = FACE_POS_Y; end
            if (neg_d[2] < pen) begin pen = neg_d[2]; r.idx = FACE_NEG_Z; end
            if (pos_d[2] < pen) begin pen = pos_d[2]; r.idx = FACE_POS_Z; end
            if (pen < 0) pen = 0;
            if (pen > longint'(PEN_MAX)) pen = longint'(PEN_MAX);
            r.hit = 1'b1;
            r.pen = pen[PW-1:0];
        end
        return r;
    endfunction

    function automatic t_box_pair cube_pair(logic [CW-1:0] ca, logic [CW-1:0] cb,
                                            logic [HW-1:0] ha, logic [HW-1:0] hb);
        t_box_pair p;
        p = '0;
        for (int k = 0; k < 3; k++) begin
            p.ca[k] = ca;
            p.cb[k] = cb;
            p.ha[k] = ha;
            p.hb[k] = hb;
        end
        return p;
    endfunction

    function automatic t_axis_span rand_axis(logic noise);
        t_axis_span a;
        int         sa;
        int         sb;
        logic [HW-1:0] ma;
        logic [HW-1:0] mb;
        longint     t;
        longint     d;
        longint     ca;
        longint     cb;
        logic [63:0] raw;
        if (noise) begin
            a.ca = $urandom;
            a.cb = $urandom;
            a.ha = HW'($urandom);
            a.hb = HW'($urandom);
            return a;
        end
        sa = $urandom_range(0, 31);
        sb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : sa;
        ma = (sa >= 31) ? '1 : ((31'd1 << sa) - 31'd1);
        mb = (sb >= 31) ? '1 : ((31'd1 << sb) - 31'd1);
        a.ha = HW'($urandom) & ma;
        a.hb = HW'($urandom) & mb;
        t = longint'(a.ha) + longint'(a.hb);
        raw = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0) d = t;
        else if (t > 0) d = longint'(raw >> 1) % t;
        else d = 0;
        if ($urandom_range(0, 1) == 1) d = -d;
        ca = longint'($signed($urandom));
        cb = ca + d;
        if (cb > CTR_MAX || cb < CTR_MIN) begin
            ca = -(d >>> 1);
            cb = ca + d;
        end
        a.ca = ca[CW-1:0];
        a.cb = cb[CW-1:0];
        return a;
    endfunction

    function automatic t_box_pair rand_pair(int kind);
        t_box_pair  p;
        t_axis_span a;
        int         broken;
        p = '0;
        broken = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            a = rand_axis(kind == 9 || (kind == 8 && k == broken));
            p.ca[k] = a.ca;
            p.cb[k] = a.cb;
            p.ha[k] = a.ha;
            p.hb[k] = a.hb;
        end
        return p;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        // degenerate, touching and just-overlapping boxes
        pending_pairs.push_back(cube_pair('0, '0, '0, '0));
        pending_pairs.push_back(cube_pair('0, '0, 31'h10000, 31'h10000));
        build_pair = cube_pair('0, '0, 31'h10000, 31'h10000);
        build_pair.cb[0] = 32'h20000;
        pending_pairs.push_back(build_pair);
        build_pair.cb[0] = 32'h1ffff;
        pending_pairs.push_back(build_pair);
        build_pair = cube_pair('0, '0, 31'h10000, 31'h10000);
        build_pair.cb[2] = 32'hfffe0000;
        pending_pairs.push_back(build_pair);
        // each face the shallowest in turn
        for (int k = 0; k < 3; k++) begin
            build_pair = cube_pair('0, '0, 31'h10000, 31'h10000);
            build_pair.cb[k] = 32'hfffe8000;
            pending_pairs.push_back(build_pair);
            build_pair.cb[k] = 32'h18000;
            pending_pairs.push_back(build_pair);
        end
        // equal depths on two faces
        build_pair = cube_pair('0, '0, 31'h10000, 31'h10000);
        build_pair.cb[0] = 32'h8000;
        build_pair.cb[1] = 32'h8000;
        pending_pairs.push_back(build_pair);
        build_pair.cb[0] = 32'hffff8000;
        build_pair.cb[1] = 32'h0;
        build_pair.cb[2] = 32'h8000;
        pending_pairs.push_back(build_pair);
        // range extremes
        pending_pairs.push_back(cube_pair(32'h80000000, 32'h7fffffff, '1, '1));
        pending_pairs.push_back(cube_pair(32'h7fffffff, 32'h80000000, '1, '1));
        pending_pairs.push_back(cube_pair(32'h80000000, 32'h80000000, '1, '1));
        pending_pairs.push_back(cube_pair(32'h7fffffff, 32'h7fffffff, '1, '1));
        pending_pairs.push_back(cube_pair(32'h7fffffff, 32'h7fffffff, '1, '0));
        pending_pairs.push_back(cube_pair(32'h80000000, 32'h80000000, '0, '1));
        pending_pairs.push_back(cube_pair('0, 32'h7fffffff, 31'h40000000, 31'h40000000));
        pending_pairs.push_back(cube_pair('0, 32'h80000000, 31'h40000000, 31'h40000000));
        pending_pairs.push_back(cube_pair(32'hffffffff, '0, 31'h1, '0));

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            mode = $urandom_range(0, 9);
            build_pair = rand_pair(mode);
            build_pair.wait_drain = (n == DRAIN_AT);
            pending_pairs.push_back(build_pair);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_contacts.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("aabb_overlap_penetration_axis: match");
        end else begin
            $display("aabb_overlap_penetration_axis: mismatch");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_contacts.push_back(predict_contact(drv_cur));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_idle > 0) begin
                    src_idle--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_pairs.size() > 0 &&
                             !(pending_pairs[0].wait_drain && expected_contacts.size() > 0)) begin
                    drv_cur = pending_pairs.pop_front();
                    s_axis_tdata <= pack_pair(drv_cur);
                    s_axis_tvalid <= 1'b1;
                    sent_cnt++;
                    quiet_tail <= (pending_pairs.size() < TAIL_PAIRS);
                    if (pending_pairs.size() >= TAIL_PAIRS && ((sent_cnt >> 6) % 4) != 1 &&
                        $urandom_range(0, 7) == 0) begin
                        src_idle = $urandom_range(1, 12);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_contact.hit = m_axis_tdata[M_HIT_BIT];
                got_contact.idx = m_axis_tdata[M_IDX_LSB +: IDXW];
                got_contact.pen = m_axis_tdata[M_PEN_LSB +: PW];
                if (expected_contacts.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected transfer: hit=%0d idx=%0d pen=%h",
                                 got_contact.hit, got_contact.idx, got_contact.pen);
                    end
                end else begin
                    want_contact = expected_contacts.pop_front();
                    if (got_contact.hit !== want_contact.hit ||
                        got_contact.idx !== want_contact.idx ||
                        got_contact.pen !== want_contact.pen) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display({"transfer %0d: expected hit=%0d idx=%0d pen=%h, ",
                                      "got hit=%0d idx=%0d pen=%h"},
                                     res_cnt, want_contact.hit, want_contact.idx,
                                     want_contact.pen, got_contact.hit, got_contact.idx,
                                     got_contact.pen);
                        end
                    end
                end
                res_cnt++;
                if (res_cnt == LONG_HOLD_AT) sink_hold = LONG_HOLD;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && ((res_cnt >> 6) % 4) != 2 &&
                         $urandom_range(0, 9) == 0) begin
                sink_hold = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("aabb_overlap_penetration_axis: mismatch");
                $finish;
            end
        end
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/aop_pkg.sv
rtl/aop_axis.sv
rtl/aop_select.sv
rtl/aabb_overlap_penetration_axis.sv
rtl/aop_checker.sv
dv/testbench.sv
